FILE: hw/rtl/linear_probe_hash_table_defines.svh
// Assertion macros for the linear probing hash table.
// Each use expands to one labelled concurrent assertion, clocked on the
// rising edge and switched off while reset is held low.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht assertion failed");

`endif

FILE: hw/rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 3;
  localparam int SIZE_W = 7;
  localparam int CNT_W  = 7;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 7'd64;

  typedef enum logic [STAT_W-1:0] {
    ST_PROBED    = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_t;

  // Classified operation handed from the front end to the probe engine.
  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  home;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lpht_fifo.sv
// ----------------------------------------------------------------------------
// lpht_fifo
// Small register queue used between the front end and the probe engine
// and in front of the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_front.sv
// ----------------------------------------------------------------------------
// lpht_front
// Accepts operations and works out the home slot, the key modulo the table
// size taken as non-negative, four key bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_front
  import lpht_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   size,
  input  logic                               in_push,
  input  logic                               in_mode,
  input  logic [KEY_W-1:0]                   in_key,
  output logic                               in_full,
  input  logic                               cmd_full,
  output logic                               cmd_push,
  output cmd_t                               cmd
);

  localparam int SZW       = $clog2(TABLE_DEPTH + 1);
  localparam int IW        = $clog2(TABLE_DEPTH);
  localparam int TW        = IW + 4;
  localparam int DIV_STEPS = KEY_W / 4;
  localparam int STW       = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_t;

  fstate_t          state_r;
  mode_t            mode_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] mag_r;
  logic             neg_r;
  logic [IW-1:0]    rem_r;
  logic [STW-1:0]   step_r;
  logic [TW-1:0]    part;
  logic [IW-1:0]    rem_nxt;
  logic [SZW-1:0]   comp;
  logic [IW-1:0]    home;

  // One radix-16 digit of restoring division: the partial remainder stays
  // below the size, so four conditional subtractions settle it.
  always_comb begin
    part = {rem_r, mag_r[KEY_W-1 -: 4]};
    for (int j = 3; j >= 0; j--) begin
      if (part >= (TW'(size) << j)) begin
        part = part - (TW'(size) << j);
      end
    end
    rem_nxt = part[IW-1:0];
  end

  // A negative key has its remainder folded back into the range.
  assign comp = size - SZW'(rem_r);
  assign home = (neg_r && (rem_r != '0)) ? comp[IW-1:0] : rem_r;

  assign in_full  = (state_r != F_IDLE);
  assign cmd_push = (state_r == F_PUSH) && !cmd_full;

  always_comb begin
    cmd.mode = mode_r;
    cmd.key  = key_r;
    cmd.home = SLOT_W'(home);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_push) begin
            mode_r  <= mode_t'(in_mode);
            key_r   <= in_key;
            mag_r   <= in_key[KEY_W-1] ? (~in_key + 1'b1) : in_key;
            neg_r   <= in_key[KEY_W-1];
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r  <= rem_nxt;
          mag_r  <= mag_r << 4;
          step_r <= step_r + 1'b1;
          if (step_r == STW'(DIV_STEPS - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!cmd_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_back.sv
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: walks the table from the home slot, reading and then
// checking each slot in turn, and reports each probed slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_back
  import lpht_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   size,
  input  logic                               cmd_empty,
  input  cmd_t                               cmd,
  output logic                               cmd_pop,
  input  logic                               res_full,
  output logic                               res_push,
  output result_t                            res
);

  localparam int SZW = $clog2(TABLE_DEPTH + 1);
  localparam int IW  = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CHECK
  } bstate_t;

  bstate_t          state_r;
  mode_t            mode_r;
  logic [KEY_W-1:0] key_r;
  logic [IW-1:0]    idx_r;
  logic [SZW-1:0]   n_r;
  logic [TABLE_DEPTH-1:0] used_r;
  logic [CNT_W-1:0] count_r;
  logic [KEY_W-1:0] rdata_r;
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];

  logic             table_full;
  logic             last_probe;
  logic [SZW-1:0]   idx_inc;
  logic [IW-1:0]    idx_next;
  logic             wr_en;
  logic             done;

  assign table_full = (count_r >= CNT_W'(size));
  assign last_probe = (n_r == (size - 1'b1));
  assign idx_inc    = SZW'(idx_r) + 1'b1;
  assign idx_next   = (idx_inc >= size) ? '0 : idx_inc[IW-1:0];
  assign cmd_pop    = (state_r == B_IDLE) && !cmd_empty && !res_full;

  always_comb begin
    res_push   = 1'b0;
    res.slot   = SLOT_W'(idx_r);
    res.status = ST_PROBED;
    res.last   = 1'b0;
    wr_en      = 1'b0;
    done       = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (cmd_pop && (cmd.mode == MODE_INSERT) && table_full) begin
          res_push   = 1'b1;
          res.slot   = '0;
          res.status = ST_FULL;
          res.last   = 1'b1;
        end
      end
      B_CHECK: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (mode_r == MODE_INSERT) begin
            if (!used_r[idx_r]) begin
              res.status = ST_INSERTED;
              res.last   = 1'b1;
              wr_en      = 1'b1;
              done       = 1'b1;
            end else if (last_probe) begin
              // Cannot happen while the count is below the size; kept as a bound.
              res.slot   = '0;
              res.status = ST_FULL;
              res.last   = 1'b1;
              done       = 1'b1;
            end
          end else begin
            if (!used_r[idx_r]) begin
              res.status = ST_NOT_FOUND;
              res.last   = 1'b1;
              done       = 1'b1;
            end else if (rdata_r == key_r) begin
              res.status = ST_FOUND;
              res.last   = 1'b1;
              done       = 1'b1;
            end else if (last_probe) begin
              res.status = ST_NOT_FOUND;
              res.last   = 1'b1;
              done       = 1'b1;
            end
          end
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      used_r  <= '0;
      count_r <= '0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (cmd_pop) begin
            mode_r <= cmd.mode;
            key_r  <= cmd.key;
            idx_r  <= cmd.home[IW-1:0];
            n_r    <= '0;
            if (!((cmd.mode == MODE_INSERT) && table_full)) begin
              state_r <= B_READ;
            end
          end
        end
        B_READ: begin
          state_r <= B_CHECK;
        end
        B_CHECK: begin
          if (wr_en) begin
            used_r[idx_r] <= 1'b1;
            count_r       <= count_r + 1'b1;
          end
          if (res_push) begin
            if (done) begin
              state_r <= B_IDLE;
            end else begin
              idx_r   <= idx_next;
              n_r     <= n_r + 1'b1;
              state_r <= B_READ;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  // Key store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[idx_r] <= key_r;
    end
    rdata_r <= key_mem[idx_r];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table.sv
// Flow: an operation is captured by the front end, goes through eight
// radix-16 modulo steps and is handed off to the probe engine, which reads
// and then checks each probed slot; each result beat goes to the result queue.
// The front end takes one operation at a time, but can accept another while
// the probe engine, with its single key store read port, works on the last.
// Reset clears the occupied flags and entry count and sets table_size to 64.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert and search of
// signed 32-bit keys, one result beat per probed slot.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_wdata,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_mode,
  input  logic signed [KEY_W-1:0]  in_key,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [SLOT_W-1:0]        out_slot_index,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_last
);

  localparam int SZW = $clog2(TABLE_DEPTH + 1);
  localparam logic [SIZE_W-1:0] DEPTH_CFG = SIZE_W'(TABLE_DEPTH);

  logic [SIZE_W-1:0]       table_size_r;
  logic [SIZE_W-1:0]       eff_size;
  logic [SZW-1:0]          size;

  cmd_t                    front_cmd;
  cmd_t                    back_cmd;
  logic [$bits(cmd_t)-1:0] front_cmd_bits;
  logic [$bits(cmd_t)-1:0] back_cmd_bits;
  logic                    cmd_push;
  logic                    cmd_full;
  logic                    cmd_pop;
  logic                    cmd_empty;

  result_t                    res;
  result_t                    out_res;
  logic [$bits(result_t)-1:0] res_bits;
  logic [$bits(result_t)-1:0] out_res_bits;
  logic                       res_push;
  logic                       res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // A size of zero behaves as one, and anything above the depth as the depth.
  assign eff_size = (table_size_r == '0) ? SIZE_W'(1) :
                    (table_size_r > DEPTH_CFG) ? DEPTH_CFG : table_size_r;
  assign size     = SZW'(eff_size);

  lpht_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .size     (size),
    .in_push  (in_push),
    .in_mode  (in_mode),
    .in_key   (in_key),
    .in_full  (in_full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  assign front_cmd_bits = front_cmd;
  assign back_cmd       = cmd_t'(back_cmd_bits);

  lpht_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (front_cmd_bits),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd_bits),
    .empty (cmd_empty)
  );

  lpht_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  assign res_bits = res;
  assign out_res  = result_t'(out_res_bits);

  lpht_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_bits),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res_bits),
    .empty (out_empty)
  );

  assign out_slot_index = out_res.slot;
  assign out_status     = out_res.status;
  assign out_last       = out_res.last;

endmodule

`default_nettype wire

FILE: hw/rtl/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the hash table's result stream and input side.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_probe_hash_table_defines.svh"

module lpht_checker
  import lpht_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [SLOT_W-1:0] out_slot_index,
  input logic [STAT_W-1:0] out_status,
  input logic              out_last
);

  localparam logic [SLOT_W:0] DEPTH_LIM = (SLOT_W + 1)'(TABLE_DEPTH);

  // Only the closing beat of an operation may carry an outcome.
  `LPHT_ASSERT_NOW(a_mid_beat_probed, clk, rst_n, !out_empty && !out_last, out_status == ST_PROBED)
  `LPHT_ASSERT_NOW(a_full_single, clk, rst_n, !out_empty && (out_status == ST_FULL), out_last && (out_slot_index == '0))
  `LPHT_ASSERT_NOW(a_slot_range, clk, rst_n, !out_empty, {1'b0, out_slot_index} < DEPTH_LIM)
  // The front end works on one operation at a time.
  `LPHT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_push && !in_full, in_full)
  `LPHT_ASSERT_NEXT(a_hold_result, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_slot_index) && $stable(out_status) && $stable(out_last))

endmodule

bind linear_probe_hash_table lpht_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_lpht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_push        (in_push),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_slot_index (out_slot_index),
  .out_status     (out_status),
  .out_last       (out_last)
);

`default_nettype wire
